// ----- design/matrix_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// matrix_multiply_assert.svh
// Assertion macros for the matrix multiply block. Clocked on clk, and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define MM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix_multiply: assertion failed");

// Next-cycle implication.
`define MM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix_multiply: assertion failed");

`endif

// ----- design/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 16;
  localparam int ACC_W   = 32;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_WRITE_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY = 2'd2;

  // Marker that travels with each (row, col) token down the chain
  typedef struct packed {
    logic valid;
    logic last;
  } mm_ctl_t;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_ISSUE,
    MM_DRAIN
  } mm_state_t;

endpackage

// ----- design/mm_cell.sv -----
// ----------------------------------------------------------------------------
// mm_cell
// One cell of the product chain: holds column k of A and row k of B, and
// adds A[i][k]*B[k][j] to the partial sum passing through. Two stages.
// ----------------------------------------------------------------------------
module mm_cell
  import mm_pkg::*;
#(
  parameter int CELL_IDX     = 0,
  parameter int MAX_N        = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic [$clog2(MAX_N+1)-1:0]     eff_size,
  input  logic                           wr_a_en,
  input  logic [$clog2(MAX_N)-1:0]       wr_a_addr,
  input  logic                           wr_b_en,
  input  logic [$clog2(MAX_N)-1:0]       wr_b_addr,
  input  logic signed [ELEMENT_BITS-1:0] wr_data,
  input  logic [$clog2(MAX_N)-1:0]       row_i,
  input  logic [$clog2(MAX_N)-1:0]       col_i,
  input  logic [ACC_W-1:0]               sum_i,
  input  mm_ctl_t                        ctl_i,
  output logic [$clog2(MAX_N)-1:0]       row_o,
  output logic [$clog2(MAX_N)-1:0]       col_o,
  output logic [ACC_W-1:0]               sum_o,
  output mm_ctl_t                        ctl_o
);

  localparam int IW     = $clog2(MAX_N);
  localparam int SZW    = $clog2(MAX_N+1);
  localparam int PROD_W = 2 * ELEMENT_BITS;

  logic signed [ELEMENT_BITS-1:0] a_col_r [MAX_N];
  logic signed [ELEMENT_BITS-1:0] b_row_r [MAX_N];

  logic [ACC_W-1:0] prod_r;
  logic [ACC_W-1:0] psum_r;
  logic [IW-1:0]    row1_r, col1_r;
  mm_ctl_t          ctl1_r;

  logic [ACC_W-1:0] sum2_r;
  logic [IW-1:0]    row2_r, col2_r;
  mm_ctl_t          ctl2_r;

  logic cell_on;

  // Cells beyond the size in use contribute nothing
  assign cell_on = SZW'(CELL_IDX) < eff_size;

  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      a_col_r[wr_a_addr] <= wr_data;
    end
    if (wr_b_en) begin
      b_row_r[wr_b_addr] <= wr_data;
    end
  end

  // Stage one: multiply, hold the incoming sum alongside
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cell_on) begin
        prod_r <= ACC_W'(PROD_W'(a_col_r[row_i]) * PROD_W'(b_row_r[col_i]));
      end else begin
        prod_r <= '0;
      end
      psum_r <= sum_i;
      row1_r <= row_i;
      col1_r <= col_i;
    end
  end

  // Stage two: accumulate, wrapping at 32 bits
  always_ff @(posedge clk) begin
    if (advance) begin
      sum2_r <= psum_r + prod_r;
      row2_r <= row1_r;
      col2_r <= col1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (advance) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  assign row_o = row2_r;
  assign col_o = col2_r;
  assign sum_o = sum2_r;
  assign ctl_o = ctl2_r;

endmodule

// ----- design/mm_seq.sv -----
// ----------------------------------------------------------------------------
// mm_seq
// Sequencer: walks (row, col) over the product matrix in row-major order,
// one token into the chain per advancing cycle, then waits for the drain.
// ----------------------------------------------------------------------------
module mm_seq
  import mm_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       advance,
  input  logic                       out_done,
  input  logic [$clog2(MAX_N+1)-1:0] eff_size,
  output logic                       busy,
  output logic [$clog2(MAX_N)-1:0]   inj_row,
  output logic [$clog2(MAX_N)-1:0]   inj_col,
  output mm_ctl_t                    inj_ctl
);

  localparam int IW  = $clog2(MAX_N);
  localparam int SZW = $clog2(MAX_N+1);

  mm_state_t     state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic          row_end;
  logic          at_end;

  assign row_end = SZW'(j_r) == (eff_size - SZW'(1));
  assign at_end  = row_end && (SZW'(i_r) == (eff_size - SZW'(1)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MM_IDLE: begin
        if (start) begin
          state_nxt = MM_ISSUE;
        end
      end
      MM_ISSUE: begin
        if (advance && at_end) begin
          state_nxt = MM_DRAIN;
        end
      end
      MM_DRAIN: begin
        if (out_done) begin
          state_nxt = MM_IDLE;
        end
      end
      default: state_nxt = MM_IDLE;
    endcase
  end

  // Index counters
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (state_r == MM_IDLE) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (state_r == MM_ISSUE && advance) begin
      if (row_end) begin
        j_nxt = '0;
        i_nxt = i_r + IW'(1);
      end else begin
        j_nxt = j_r + IW'(1);
      end
    end
  end

  // Outputs
  always_comb begin
    busy          = 1'b1;
    inj_ctl.valid = 1'b0;
    inj_ctl.last  = 1'b0;
    unique case (state_r)
      MM_IDLE: begin
        busy = 1'b0;
      end
      MM_ISSUE: begin
        inj_ctl.valid = 1'b1;
        inj_ctl.last  = at_end;
      end
      MM_DRAIN: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign inj_row = i_r;
  assign inj_col = j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

// ----- design/matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply
// Square matrix multiply engine built as a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transfer per item. Opcode write-A / write-B
//   stores in_value at (in_row, in_col); writes at or beyond the size in use
//   are dropped. Opcode multiply emits C = A * B, row-major, with out_last
//   on the final element. Any other opcode is dropped.
//   Config channel (cfg_*): cfg_data sets the size in use (0 acts as 1, above
//   MAX_N acts as MAX_N). Write it only while the block is idle.
//   Results: after the multiply transfer each token passes the cell chain,
//   MAX_N cells of two stages each, and the output register; results then
//   follow one per cycle while out_ready is high. in_ready returns the
//   cycle after the last result is taken.
//   Loads: the block takes loads back to back while idle; the input is
//   held off while a multiply is in flight.
//   Reset: size returns to 8; stored elements are undefined until written.
//   Stall: while a result waits on out_ready the whole chain and the
//   sequencer hold, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "matrix_multiply_assert.svh"

module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_N        = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_opcode,
  input  logic [$clog2(MAX_N)-1:0]   in_row,
  input  logic [$clog2(MAX_N)-1:0]   in_col,
  input  logic signed [VALUE_W-1:0]  in_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(MAX_N)-1:0]   out_row,
  output logic [$clog2(MAX_N)-1:0]   out_col,
  output logic signed [ACC_W-1:0]    out_product,
  output logic                       out_last,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int IW  = $clog2(MAX_N);
  localparam int SZW = $clog2(MAX_N+1);

  // Size register and its effective value
  logic [CFG_W-1:0] size_r;
  logic [SZW-1:0]   eff_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  // Clamp into 1..MAX_N
  always_comb begin
    priority if (size_r == '0) begin
      eff_size = SZW'(1);
    end else if (int'(size_r) > MAX_N) begin
      eff_size = SZW'(MAX_N);
    end else begin
      eff_size = SZW'(size_r);
    end
  end

  // Input decode
  logic in_xfer;
  logic in_range;
  logic wr_a, wr_b, start;
  logic signed [ELEMENT_BITS-1:0] wr_data;

  assign in_xfer  = in_valid && in_ready;
  assign in_range = (SZW'(in_row) < eff_size) && (SZW'(in_col) < eff_size);
  assign wr_data  = ELEMENT_BITS'(in_value);

  always_comb begin
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    unique case (in_opcode)
      OP_WRITE_A:  wr_a  = in_xfer && in_range;
      OP_WRITE_B:  wr_b  = in_xfer && in_range;
      OP_MULTIPLY: start = in_xfer;
      default:     start = 1'b0;  // unused opcode: drop the transfer
    endcase
  end

  // Advance the chain unless a result is held waiting on the receiver
  logic advance;
  logic out_valid_r;
  logic out_done;
  logic busy;

  assign advance  = !out_valid_r || out_ready;
  assign out_done = out_valid_r && out_ready && out_last;
  assign in_ready = !busy;

  // Sequencer
  logic [IW-1:0] ch_row [MAX_N+1];
  logic [IW-1:0] ch_col [MAX_N+1];
  logic [ACC_W-1:0] ch_sum [MAX_N+1];
  mm_ctl_t       ch_ctl [MAX_N+1];

  mm_seq #(
    .MAX_N (MAX_N)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .advance  (advance),
    .out_done (out_done),
    .eff_size (eff_size),
    .busy     (busy),
    .inj_row  (ch_row[0]),
    .inj_col  (ch_col[0]),
    .inj_ctl  (ch_ctl[0])
  );

  assign ch_sum[0] = '0;

  // Cell k holds column k of A and row k of B: an A write lands in the cell
  // named by its column, a B write in the cell named by its row.
  for (genvar k = 0; k < MAX_N; k++) begin : g_cell
    mm_cell #(
      .CELL_IDX     (k),
      .MAX_N        (MAX_N),
      .ELEMENT_BITS (ELEMENT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .eff_size  (eff_size),
      .wr_a_en   (wr_a && (in_col == IW'(k))),
      .wr_a_addr (in_row),
      .wr_b_en   (wr_b && (in_row == IW'(k))),
      .wr_b_addr (in_col),
      .wr_data   (wr_data),
      .row_i     (ch_row[k]),
      .col_i     (ch_col[k]),
      .sum_i     (ch_sum[k]),
      .ctl_i     (ch_ctl[k]),
      .row_o     (ch_row[k+1]),
      .col_o     (ch_col[k+1]),
      .sum_o     (ch_sum[k+1]),
      .ctl_o     (ch_ctl[k+1])
    );
  end

  // Output register at the tail of the chain
  logic [IW-1:0]    out_row_r, out_col_r;
  logic [ACC_W-1:0] out_sum_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ch_ctl[MAX_N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ch_ctl[MAX_N].valid) begin
      out_row_r  <= ch_row[MAX_N];
      out_col_r  <= ch_col[MAX_N];
      out_sum_r  <= ch_sum[MAX_N];
      out_last_r <= ch_ctl[MAX_N].last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_product = out_sum_r;
  assign out_last    = out_last_r;

  // Checks
  `MM_ASSERT_NOW(a_idle_no_result, in_ready, !out_valid)
  `MM_ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && out_last, in_ready)
  `MM_ASSERT_NOW(a_last_on_diagonal, out_valid && out_last, out_row == out_col)

endmodule
